// ----- rtl/core/bounded_seen_id_filter_core_assert.svh -----
`ifndef BOUNDED_SEEN_ID_FILTER_CORE_ASSERT_SVH
`define BOUNDED_SEEN_ID_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSIF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSIF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bsif_pkg.sv -----
package bsif_pkg;

  // Ring geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDENT_W  = 32;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_MARK    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // Sequencer to slot store
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDENT_W-1:0] wr_ident;
    logic               clr_en;
    logic [IDX_W-1:0]   clr_addr;
  } store_req_t;

  // Slot store read response, registered and valid in the cycle after the read
  typedef struct packed {
    logic               vld;
    logic [IDX_W-1:0]   addr;
    logic [IDENT_W-1:0] ident;
    logic               member;
  } store_rsp_t;

endpackage

// ----- rtl/core/bsif_store.sv -----
module bsif_store
  import bsif_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);

  logic [IDENT_W-1:0] ident_mem [CAPACITY];
  logic [CAPACITY-1:0] member_q;
  logic                rsp_vld_q;
  logic [IDX_W-1:0]    rsp_addr_q;
  logic [IDENT_W-1:0]  rsp_ident_q;
  logic                rsp_member_q;

  // Write identifier slots, read one slot a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      ident_mem[req_i.wr_addr] <= req_i.wr_ident;
    end
    if (req_i.rd_en) begin
      rsp_ident_q  <= ident_mem[req_i.rd_addr];
      rsp_member_q <= member_q[req_i.rd_addr];
      rsp_addr_q   <= req_i.rd_addr;
    end
  end

  // Member flags: set on write, drop one on a hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q  <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= req_i.rd_en;
      if (req_i.wr_en) begin
        member_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.clr_en) begin
        member_q[req_i.clr_addr] <= 1'b0;
      end
    end
  end

  assign rsp_o.vld    = rsp_vld_q;
  assign rsp_o.addr   = rsp_addr_q;
  assign rsp_o.ident  = rsp_ident_q;
  assign rsp_o.member = rsp_member_q;

endmodule

// ----- rtl/core/bsif_seq.sv -----
module bsif_seq
  import bsif_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_vld_i,
  input  op_e                req_op_i,
  input  logic [IDENT_W-1:0] req_ident_i,
  output logic               req_rdy_o,
  output logic               res_vld_o,
  output logic               res_acc_o,
  input  logic               res_rdy_i,
  output store_req_t         st_req_o,
  input  store_rsp_t         st_rsp_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FIND     = 3'd1;
  localparam logic [2:0] S_FIND_END = 3'd2;
  localparam logic [2:0] S_WRITE    = 3'd3;
  localparam logic [2:0] S_DROP     = 3'd4;
  localparam logic [2:0] S_DROP_END = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   oldest_q, oldest_d;
  logic               found_q, found_d;
  logic [IDENT_W-1:0] key_q, key_d;
  logic [IDENT_W-1:0] dropped_q, dropped_d;
  logic               acc_q, acc_d;

  logic               hit;
  logic [IDX_W-1:0]   rsp_off;
  logic               rsp_in_ring;
  logic [IDX_W:0]     app_sum;
  logic [IDX_W-1:0]   app_pos;
  logic [IDX_W-1:0]   oldest_nxt;

  // Ring offset of the returned slot; only slots inside the ring count
  assign rsp_off     = (st_rsp_i.addr >= oldest_q) ? (st_rsp_i.addr - oldest_q) :
                       IDX_W'(CAP_EXT + st_rsp_i.addr - oldest_q);
  assign rsp_in_ring = (CNT_W'(rsp_off) < count_q);

  // Shared compare unit: one slot against the key each cycle
  assign hit = st_rsp_i.vld && st_rsp_i.member && rsp_in_ring &&
               (st_rsp_i.ident == key_q);

  // Ring positions: append slot and successor of the oldest slot
  assign app_sum    = {1'b0, oldest_q} + {1'b0, count_q[IDX_W-1:0]};
  assign app_pos    = (app_sum >= CAP_EXT) ? IDX_W'(app_sum - CAP_EXT) : app_sum[IDX_W-1:0];
  assign oldest_nxt = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;

  // Sequence one request through the scans
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    oldest_d  = oldest_q;
    found_d   = found_q;
    key_d     = key_q;
    dropped_d = dropped_q;
    acc_d     = acc_q;
    req_rdy_o = 1'b0;
    res_vld_o = 1'b0;
    st_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        req_rdy_o = 1'b1;
        if (req_vld_i) begin
          key_d   = req_ident_i;
          acc_d   = 1'b0;
          cnt_d   = '0;
          found_d = 1'b0;
          case (req_op_i)
            OP_MARK: begin
              state_d = (req_ident_i == '0) ? S_DONE : S_FIND;
            end
            OP_RELEASE: begin
              state_d = (req_ident_i == '0) ? S_DONE : S_DROP;
            end
            OP_CLEAR: begin
              // Empty the ring; stale member flags fall outside it
              count_d  = '0;
              oldest_d = '0;
              state_d  = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_FIND, S_DROP: begin
        st_req_o.rd_en   = 1'b1;
        st_req_o.rd_addr = cnt_q;
        if (cnt_q == LAST_IDX) begin
          state_d = (state_q == S_FIND) ? S_FIND_END : S_DROP_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIND_END: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (found_q) begin
          state_d = S_DONE;
        end else if (count_q < CAP_CNT) begin
          st_req_o.wr_en    = 1'b1;
          st_req_o.wr_addr  = app_pos;
          st_req_o.wr_ident = key_q;
          count_d           = count_q + 1'b1;
          acc_d             = 1'b1;
          state_d           = S_DONE;
        end else begin
          // Full ring: overwrite the oldest slot, then drop its old identifier
          st_req_o.wr_en    = 1'b1;
          st_req_o.wr_addr  = oldest_q;
          st_req_o.wr_ident = key_q;
          oldest_d          = oldest_nxt;
          key_d             = dropped_q;
          acc_d             = 1'b1;
          cnt_d             = '0;
          state_d           = S_DROP;
        end
      end
      S_DROP_END: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        res_vld_o = 1'b1;
        if (res_rdy_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Consume scan responses: record hits, or drop membership
    if ((state_q == S_FIND) || (state_q == S_FIND_END)) begin
      if (hit) begin
        found_d = 1'b1;
      end
      if (st_rsp_i.vld && (st_rsp_i.addr == oldest_q)) begin
        dropped_d = st_rsp_i.ident;
      end
    end
    if (((state_q == S_DROP) || (state_q == S_DROP_END)) && hit) begin
      st_req_o.clr_en   = 1'b1;
      st_req_o.clr_addr = st_rsp_i.addr;
    end
  end

  assign res_acc_o = acc_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      count_q  <= '0;
      oldest_q <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      found_q  <= found_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    dropped_q <= dropped_d;
    acc_q     <= acc_d;
  end

endmodule

// ----- rtl/core/bounded_seen_id_filter_core.sv -----
// Steps: mark scans all slots in the shared compare unit and, if absent,
//   appends the identifier, or on a full ring overwrites the oldest slot and
//   scans again to drop the evicted identifier; release scans once; clear, a
//   zero identifier and other codes go straight to the result. Requests: one
//   at a time, the next taken once the result is in the output register; the
//   slot scan runs at one slot a cycle. Reset: asynchronous, active low.
module bounded_seen_id_filter_core
  import bsif_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // [1:0] op, [33:2] ident, [39:34] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // [0] accepted, [7:1] zero
);

  store_req_t st_req;
  store_rsp_t st_rsp;
  logic       res_vld;
  logic       res_acc;
  logic       res_rdy;
  logic       out_vld_q, out_vld_d;
  logic       out_acc_q, out_acc_d;

  bsif_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_vld_i   (s_axis_tvalid),
    .req_op_i    (op_e'(s_axis_tdata[OP_W-1:0])),
    .req_ident_i (s_axis_tdata[OP_W+IDENT_W-1:OP_W]),
    .req_rdy_o   (s_axis_tready),
    .res_vld_o   (res_vld),
    .res_acc_o   (res_acc),
    .res_rdy_i   (res_rdy),
    .st_req_o    (st_req),
    .st_rsp_i    (st_rsp)
  );

  bsif_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .rsp_o  (st_rsp)
  );

  // Output register: load a result when empty or being taken
  assign res_rdy = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    out_acc_d = out_acc_q;
    if (res_vld && res_rdy) begin
      out_vld_d = 1'b1;
      out_acc_d = res_acc;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q <= out_acc_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(M_DATA_W-1){1'b0}}, out_acc_q};

endmodule

// ----- rtl/core/bsif_checker.sv -----
`include "bounded_seen_id_filter_core_assert.svh"

module bsif_checker
  import bsif_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A taken request keeps the input closed while it is worked on
  `BSIF_ASSERT_NXT(a_busy_after_req, in_fire, !s_axis_tready, "ready right after a request")
  // Padding bits of a result are zero
  `BSIF_ASSERT(a_pad_zero, m_axis_tvalid, m_axis_tdata[M_DATA_W-1:1] == '0, "nonzero pad")
  // A stalled result stays
  `BSIF_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped while stalled")
  `BSIF_ASSERT_NXT(a_out_stable, out_stall, $stable(m_axis_tdata), "result changed in stall")

endmodule

bind bounded_seen_id_filter_core bsif_checker u_bsif_checker (.*);
